// File: design/plfd_pkg.sv
package plfd_pkg;

  // Field and port widths
  localparam int PosW     = 12;
  localparam int LevelW   = 10;
  localparam int SpeedW   = 8;
  localparam int GainW    = 4;
  localparam int ErrW     = 12;
  localparam int SumW     = 32;
  localparam int PTermW   = 8;
  localparam int DTermW   = 18;
  localparam int PdW      = 19;
  localparam int ProdW    = 64;
  localparam int IQuotW   = 19;
  localparam int ITermW   = 20;
  localparam int DiffW    = 21;
  localparam int KindW    = 2;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 8;
  localparam int InDataW  = 64;
  localparam int OutDataW = 16;

  // Position handling
  localparam logic [PosW-1:0]        POS_MAX    = 12'd4000;
  localparam logic signed [PosW:0]   CENTER_POS = 13'sd2000;

  // x / 20 for x <= 2000: (x * 3277) >> 16
  localparam logic [11:0] P_RECIP = 12'd3277;
  localparam int          P_SHIFT = 16;
  // x / 10000 for any 32-bit x: (x * 0xD1B71759) >> 45
  localparam logic [31:0] I_RECIP = 32'hD1B7_1759;
  localparam int          I_SHIFT = 45;

  // Sensor thresholds
  localparam logic [LevelW-1:0] LOST_LEVEL = 10'd100;
  localparam logic [LevelW-1:0] SIDE_LEVEL = 10'd200;
  localparam logic [LevelW-1:0] DARK_OUTER = 10'd100;
  localparam logic [LevelW-1:0] DARK_INNER = 10'd200;

  // Register reset values
  localparam logic [SpeedW-1:0] MAX_SPEED_RST   = 8'd60;
  localparam logic [GainW-1:0]  DERIV_GAIN_RST  = 4'd3;
  localparam logic              DERIV_HALVE_RST = 1'b1;
  localparam logic              FULL_STOP_RST   = 1'b0;

  typedef enum logic [CfgAddrW-1:0] {
    REG_MAX_SPEED   = 2'd0,
    REG_DERIV_GAIN  = 2'd1,
    REG_DERIV_HALVE = 2'd2,
    REG_FULL_STOP   = 2'd3
  } cfg_reg_t;

  typedef enum logic [KindW-1:0] {
    END_CONTINUE = 2'd0,
    END_LOST     = 2'd1,
    END_BRANCH   = 2'd2,
    END_DARK     = 2'd3
  } end_kind_t;

  typedef struct packed {
    logic [SpeedW-1:0] max_speed;
    logic [GainW-1:0]  deriv_gain;
    logic              deriv_halve;
    logic              full_stop;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0]   pos;
    logic [LevelW-1:0] lvl_fl;
    logic [LevelW-1:0] lvl_l;
    logic [LevelW-1:0] lvl_c;
    logic [LevelW-1:0] lvl_r;
    logic [LevelW-1:0] lvl_fr;
    logic              seg_start;
  } sample_t;

  typedef struct packed {
    logic signed [PTermW-1:0] p_term;
    logic signed [DTermW-1:0] d_term;
    logic signed [SumW-1:0]   err_sum;
    end_kind_t                kind;
  } loop_res_t;

  typedef struct packed {
    logic signed [PdW-1:0] pd_sum;
    logic [ProdW-1:0]      i_prod;
    logic                  i_neg;
    end_kind_t             kind;
  } integ_res_t;

  typedef struct packed {
    logic [SpeedW-1:0] left_drive;
    logic [SpeedW-1:0] right_drive;
    end_kind_t         kind;
  } drive_t;

endpackage

// File: design/plfd_loop.sv
module plfd_loop (
  input  logic                clk,
  input  logic                rst_n,
  input  plfd_pkg::cfg_t      cfg,
  input  logic                vld_i,
  output logic                rdy_o,
  input  plfd_pkg::sample_t   smp_i,
  output logic                vld_o,
  input  logic                rdy_i,
  output plfd_pkg::loop_res_t res_o
);

  logic                                   vld_r;
  logic                                   take;
  logic signed [plfd_pkg::ErrW-1:0]       prev_err_r;
  logic signed [plfd_pkg::SumW-1:0]       err_sum_r;
  plfd_pkg::loop_res_t                    res_r;
  plfd_pkg::loop_res_t                    res_nxt;

  logic [plfd_pkg::PosW-1:0]              pos_sat;
  logic signed [plfd_pkg::PosW:0]         err_w;
  logic signed [plfd_pkg::ErrW-1:0]       err;
  logic signed [plfd_pkg::ErrW-1:0]       prev_err;
  logic signed [plfd_pkg::SumW-1:0]       sum_old;
  logic signed [plfd_pkg::SumW:0]         sum_wide;
  logic signed [plfd_pkg::SumW-1:0]       sum_sat;
  logic signed [plfd_pkg::ErrW:0]         err_delta;
  logic signed [plfd_pkg::DTermW-1:0]     deriv_raw;
  logic signed [plfd_pkg::DTermW-1:0]     deriv;
  logic [plfd_pkg::ErrW-2:0]              err_mag;
  logic [plfd_pkg::ErrW+10:0]             p_prod;
  logic [plfd_pkg::PTermW-2:0]            p_quot;
  logic signed [plfd_pkg::PTermW-1:0]     p_term;
  plfd_pkg::end_kind_t                    kind;

  // Advance when the next stage has room
  assign rdy_o = !vld_r || rdy_i;
  assign take  = vld_i && rdy_o;
  assign vld_o = vld_r;
  assign res_o = res_r;

  // Error, integral and derivative
  always_comb begin
    pos_sat   = (smp_i.pos > plfd_pkg::POS_MAX) ? plfd_pkg::POS_MAX : smp_i.pos;
    err_w     = $signed({1'b0, pos_sat}) - plfd_pkg::CENTER_POS;
    err       = err_w[plfd_pkg::ErrW-1:0];
    prev_err  = smp_i.seg_start ? '0 : prev_err_r;
    sum_old   = smp_i.seg_start ? '0 : err_sum_r;

    sum_wide  = (plfd_pkg::SumW+1)'(sum_old) + (plfd_pkg::SumW+1)'(err);
    if (sum_wide[plfd_pkg::SumW] != sum_wide[plfd_pkg::SumW-1]) begin
      sum_sat = sum_wide[plfd_pkg::SumW] ? {1'b1, {(plfd_pkg::SumW-1){1'b0}}}
                                         : {1'b0, {(plfd_pkg::SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[plfd_pkg::SumW-1:0];
    end

    err_delta = (plfd_pkg::ErrW+1)'(err) - (plfd_pkg::ErrW+1)'(prev_err);
    deriv_raw = plfd_pkg::DTermW'(err_delta)
              * $signed({{(plfd_pkg::DTermW-plfd_pkg::GainW){1'b0}}, cfg.deriv_gain});
    // Halve with truncation toward zero
    if (cfg.deriv_halve) begin
      deriv = (deriv_raw
            + $signed({{(plfd_pkg::DTermW-1){1'b0}}, deriv_raw[plfd_pkg::DTermW-1]})) >>> 1;
    end else begin
      deriv = deriv_raw;
    end

    // Proportional term: magnitude times reciprocal of 20
    err_mag = err[plfd_pkg::ErrW-1] ? (plfd_pkg::ErrW-1)'(-err) : (plfd_pkg::ErrW-1)'(err);
    p_prod  = (plfd_pkg::ErrW+11)'(err_mag) * (plfd_pkg::ErrW+11)'(plfd_pkg::P_RECIP);
    p_quot  = p_prod[plfd_pkg::P_SHIFT +: (plfd_pkg::PTermW-1)];
    p_term  = err[plfd_pkg::ErrW-1] ? -$signed({1'b0, p_quot}) : $signed({1'b0, p_quot});
  end

  // Classify the segment end
  always_comb begin
    priority if (smp_i.lvl_l < plfd_pkg::LOST_LEVEL && smp_i.lvl_c < plfd_pkg::LOST_LEVEL &&
                 smp_i.lvl_r < plfd_pkg::LOST_LEVEL) begin
      kind = plfd_pkg::END_LOST;
    end else if (smp_i.lvl_fl > plfd_pkg::SIDE_LEVEL || smp_i.lvl_fr > plfd_pkg::SIDE_LEVEL) begin
      kind = plfd_pkg::END_BRANCH;
    end else if (cfg.full_stop &&
                 smp_i.lvl_fl > plfd_pkg::DARK_OUTER && smp_i.lvl_l > plfd_pkg::DARK_INNER &&
                 smp_i.lvl_c > plfd_pkg::DARK_INNER && smp_i.lvl_r > plfd_pkg::DARK_INNER &&
                 smp_i.lvl_fr > plfd_pkg::DARK_OUTER) begin
      kind = plfd_pkg::END_DARK;
    end else begin
      kind = plfd_pkg::END_CONTINUE;
    end
  end

  always_comb begin
    res_nxt.p_term  = p_term;
    res_nxt.d_term  = deriv;
    res_nxt.err_sum = sum_sat;
    res_nxt.kind    = kind;
  end

  // Loop state and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      prev_err_r <= '0;
      err_sum_r  <= '0;
    end else begin
      if (rdy_o) begin
        vld_r <= vld_i;
      end
      if (take) begin
        prev_err_r <= err;
        err_sum_r  <= sum_sat;
      end
    end
  end

  // Hold the stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: design/plfd_integ.sv
module plfd_integ (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  output logic                 rdy_o,
  input  plfd_pkg::loop_res_t  res_i,
  output logic                 vld_o,
  input  logic                 rdy_i,
  output plfd_pkg::integ_res_t res_o
);

  logic                        vld_r;
  logic                        take;
  logic [plfd_pkg::SumW-1:0]   sum_mag;
  plfd_pkg::integ_res_t        res_r;
  plfd_pkg::integ_res_t        res_nxt;

  assign rdy_o = !vld_r || rdy_i;
  assign take  = vld_i && rdy_o;
  assign vld_o = vld_r;
  assign res_o = res_r;

  // Integral magnitude times reciprocal of 10000; merge P and D terms
  always_comb begin
    sum_mag = res_i.err_sum[plfd_pkg::SumW-1] ? (~res_i.err_sum + plfd_pkg::SumW'(1))
                                              : res_i.err_sum;
    res_nxt.i_prod = plfd_pkg::ProdW'(sum_mag) * plfd_pkg::ProdW'(plfd_pkg::I_RECIP);
    res_nxt.i_neg  = res_i.err_sum[plfd_pkg::SumW-1];
    res_nxt.pd_sum = plfd_pkg::PdW'(res_i.p_term) + plfd_pkg::PdW'(res_i.d_term);
    res_nxt.kind   = res_i.kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: design/plfd_drive.sv
module plfd_drive (
  input  logic                 clk,
  input  logic                 rst_n,
  input  plfd_pkg::cfg_t       cfg,
  input  logic                 vld_i,
  output logic                 rdy_o,
  input  plfd_pkg::integ_res_t res_i,
  output logic                 vld_o,
  input  logic                 rdy_i,
  output plfd_pkg::drive_t     res_o
);

  logic                               vld_r;
  logic                               take;
  plfd_pkg::drive_t                   res_r;
  plfd_pkg::drive_t                   res_nxt;
  logic [plfd_pkg::IQuotW-1:0]        i_quot;
  logic signed [plfd_pkg::ITermW-1:0] i_term;
  logic signed [plfd_pkg::DiffW-1:0]  diff;
  logic signed [plfd_pkg::DiffW-1:0]  diff_clamp;
  logic signed [plfd_pkg::DiffW-1:0]  maxv;
  logic signed [plfd_pkg::DiffW-1:0]  left_w;
  logic signed [plfd_pkg::DiffW-1:0]  right_w;

  assign rdy_o = !vld_r || rdy_i;
  assign take  = vld_i && rdy_o;
  assign vld_o = vld_r;
  assign res_o = res_r;

  // Finish the integral term, sum, clamp and split into wheel drives
  always_comb begin
    i_quot = res_i.i_prod[plfd_pkg::I_SHIFT +: plfd_pkg::IQuotW];
    i_term = res_i.i_neg ? -$signed({1'b0, i_quot}) : $signed({1'b0, i_quot});
    diff   = plfd_pkg::DiffW'(res_i.pd_sum) + plfd_pkg::DiffW'(i_term);
    maxv   = $signed({{(plfd_pkg::DiffW-plfd_pkg::SpeedW){1'b0}}, cfg.max_speed});

    priority if (diff > maxv) begin
      diff_clamp = maxv;
    end else if (diff < -maxv) begin
      diff_clamp = -maxv;
    end else begin
      diff_clamp = diff;
    end

    if (diff_clamp[plfd_pkg::DiffW-1]) begin
      left_w  = maxv + diff_clamp;
      right_w = maxv;
    end else begin
      left_w  = maxv;
      right_w = maxv - diff_clamp;
    end

    // Stop both wheels at any segment end in full-stop mode
    if (cfg.full_stop && res_i.kind != plfd_pkg::END_CONTINUE) begin
      res_nxt.left_drive  = '0;
      res_nxt.right_drive = '0;
    end else begin
      res_nxt.left_drive  = left_w[plfd_pkg::SpeedW-1:0];
      res_nxt.right_drive = right_w[plfd_pkg::SpeedW-1:0];
    end
    res_nxt.kind = res_i.kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: design/pid_line_follow_drive_core.sv
// A request passes through the input, loop, integral and drive registers to out_tvalid.
// Throughput: one request per cycle while out_tready is high; each of these stages moves
// on whenever the stage after it is empty or being drained, so bubbles close up.
// Loop state (last error, integral) is updated as a request leaves the input stage.
// Reset (rst_n low, synchronous) empties the pipeline, clears the loop state and
// loads the register defaults.
module pid_line_follow_drive_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input requests
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // line_position[11:0], level_far_left[21:12], level_left[31:22],
  // level_center[41:32], level_right[51:42], level_far_right[61:52], zero pad
  input  logic [plfd_pkg::InDataW-1:0]  in_tdata,
  // segment_start[0]
  input  logic                          in_tuser,
  // Results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // left_drive[7:0], right_drive[15:8]
  output logic [plfd_pkg::OutDataW-1:0] out_tdata,
  // end_kind[1:0]
  output logic [plfd_pkg::KindW-1:0]    out_tuser,
  // Configuration writes
  input  logic                          cfg_we,
  input  logic [plfd_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [plfd_pkg::CfgDataW-1:0] cfg_wdata
);

  plfd_pkg::cfg_t       cfg_r;
  logic                 a_vld_r;
  plfd_pkg::sample_t    a_smp_r;
  plfd_pkg::sample_t    a_smp_nxt;
  logic                 loop_rdy;
  logic                 loop_vld;
  plfd_pkg::loop_res_t  loop_res;
  logic                 integ_rdy;
  logic                 integ_vld;
  plfd_pkg::integ_res_t integ_res;
  logic                 drive_rdy;
  plfd_pkg::drive_t     drive_res;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed   <= plfd_pkg::MAX_SPEED_RST;
      cfg_r.deriv_gain  <= plfd_pkg::DERIV_GAIN_RST;
      cfg_r.deriv_halve <= plfd_pkg::DERIV_HALVE_RST;
      cfg_r.full_stop   <= plfd_pkg::FULL_STOP_RST;
    end else if (cfg_we) begin
      unique case (plfd_pkg::cfg_reg_t'(cfg_addr))
        plfd_pkg::REG_MAX_SPEED:   cfg_r.max_speed   <= cfg_wdata;
        plfd_pkg::REG_DERIV_GAIN:  cfg_r.deriv_gain  <= cfg_wdata[plfd_pkg::GainW-1:0];
        plfd_pkg::REG_DERIV_HALVE: cfg_r.deriv_halve <= cfg_wdata[0];
        plfd_pkg::REG_FULL_STOP:   cfg_r.full_stop   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Unpack the request
  always_comb begin
    a_smp_nxt.pos       = in_tdata[11:0];
    a_smp_nxt.lvl_fl    = in_tdata[21:12];
    a_smp_nxt.lvl_l     = in_tdata[31:22];
    a_smp_nxt.lvl_c     = in_tdata[41:32];
    a_smp_nxt.lvl_r     = in_tdata[51:42];
    a_smp_nxt.lvl_fr    = in_tdata[61:52];
    a_smp_nxt.seg_start = in_tuser;
  end

  // Input register
  assign in_tready = !a_vld_r || loop_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_tready) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_smp_r <= a_smp_nxt;
    end
  end

  plfd_loop u_loop (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .vld_i (a_vld_r),
    .rdy_o (loop_rdy),
    .smp_i (a_smp_r),
    .vld_o (loop_vld),
    .rdy_i (integ_rdy),
    .res_o (loop_res)
  );

  plfd_integ u_integ (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (loop_vld),
    .rdy_o (integ_rdy),
    .res_i (loop_res),
    .vld_o (integ_vld),
    .rdy_i (drive_rdy),
    .res_o (integ_res)
  );

  plfd_drive u_drive (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .vld_i (integ_vld),
    .rdy_o (drive_rdy),
    .res_i (integ_res),
    .vld_o (out_tvalid),
    .rdy_i (out_tready),
    .res_o (drive_res)
  );

  assign out_tdata = {drive_res.right_drive, drive_res.left_drive};
  assign out_tuser = drive_res.kind;

endmodule

// File: design/plfd_checker.sv
module plfd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [plfd_pkg::OutDataW-1:0] out_tdata,
  input logic [plfd_pkg::KindW-1:0]    out_tuser,
  input logic                          cfg_we,
  input logic [plfd_pkg::CfgAddrW-1:0] cfg_addr,
  input logic [plfd_pkg::CfgDataW-1:0] cfg_wdata
);

  logic [plfd_pkg::SpeedW-1:0] max_sh_r;
  logic                        fs_sh_r;
  logic [plfd_pkg::SpeedW-1:0] left_d;
  logic [plfd_pkg::SpeedW-1:0] right_d;

  assign left_d  = out_tdata[7:0];
  assign right_d = out_tdata[15:8];

  // Track the max-speed and full-stop registers seen on the write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sh_r <= plfd_pkg::MAX_SPEED_RST;
      fs_sh_r  <= plfd_pkg::FULL_STOP_RST;
    end else if (cfg_we) begin
      if (plfd_pkg::cfg_reg_t'(cfg_addr) == plfd_pkg::REG_MAX_SPEED) begin
        max_sh_r <= cfg_wdata;
      end
      if (plfd_pkg::cfg_reg_t'(cfg_addr) == plfd_pkg::REG_FULL_STOP) begin
        fs_sh_r <= cfg_wdata[0];
      end
    end
  end

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // All-dark end only in full-stop mode
  a_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !fs_sh_r |-> out_tuser != plfd_pkg::END_DARK)
    else $error("all-dark end reported outside full-stop mode");

  // Full stop zeroes both drives at a segment end
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && fs_sh_r && out_tuser != plfd_pkg::END_CONTINUE |-> out_tdata == '0)
    else $error("drives not zero at segment end in full-stop mode");

  // One wheel runs at full drive and neither exceeds it
  a_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (!fs_sh_r || out_tuser == plfd_pkg::END_CONTINUE) |->
      (left_d == max_sh_r || right_d == max_sh_r) && left_d <= max_sh_r && right_d <= max_sh_r)
    else $error("drive split out of range");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind pid_line_follow_drive_core plfd_checker u_plfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_we     (cfg_we),
  .cfg_addr   (cfg_addr),
  .cfg_wdata  (cfg_wdata)
);

// File: test/pid_line_follow_drive_core_tb.sv
`timescale 1ns / 1ps

module pid_line_follow_drive_core_tb;

  localparam int     ClkPeriod   = 10;
  localparam int     IdleLimit   = 2000;
  localparam int     DrainCycles = 8;
  // length of the full-right run that builds up the integral
  localparam int     SatRunLen   = 30;
  localparam longint ErrCenter   = 2000;
  localparam longint PDivisor    = 20;
  localparam longint IDivisor    = 10000;
  localparam longint SumMax      = 64'sd2147483647;
  localparam longint SumMin      = -64'sd2147483648;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [plfd_pkg::InDataW-1:0]  in_tdata;
  logic                          in_tuser;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [plfd_pkg::OutDataW-1:0] out_tdata;
  logic [plfd_pkg::KindW-1:0]    out_tuser;
  logic                          cfg_we;
  logic [plfd_pkg::CfgAddrW-1:0] cfg_addr;
  logic [plfd_pkg::CfgDataW-1:0] cfg_wdata;

  // Register copy and loop state of the drive predictor
  logic [plfd_pkg::SpeedW-1:0] cur_speed;
  logic [plfd_pkg::GainW-1:0]  cur_gain;
  logic                        cur_halve;
  logic                        cur_stop;
  int                          last_err;
  int                          err_acc;

  plfd_pkg::drive_t drive_q[$];
  int     failures = 0;
  int     gap_max = 6;
  int     stall_max = 6;
  int     rx_hold_off = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  pid_line_follow_drive_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Advance the loop state by one sample and return the wheel drives it gives
  function automatic plfd_pkg::drive_t predict_drive(input plfd_pkg::sample_t s);
    longint                    err;
    longint                    dterm;
    longint                    sum;
    longint                    diff;
    longint                    maxv;
    longint                    left;
    longint                    right;
    logic [plfd_pkg::PosW-1:0] pos;
    plfd_pkg::end_kind_t       kind;
    plfd_pkg::drive_t          res;
    if (s.seg_start) begin
      last_err = 0;
      err_acc = 0;
    end
    pos = (s.pos > plfd_pkg::POS_MAX) ? plfd_pkg::POS_MAX : s.pos;
    err = longint'(pos) - ErrCenter;
    dterm = (err - longint'(last_err)) * longint'(cur_gain);
    if (cur_halve) dterm = dterm / 2;
    // integral saturates at the 32-bit signed limits
    sum = longint'(err_acc) + err;
    if (sum > SumMax) sum = SumMax;
    if (sum < SumMin) sum = SumMin;
    err_acc = int'(sum);
    last_err = int'(err);
    diff = err / PDivisor + sum / IDivisor + dterm;
    maxv = longint'(cur_speed);
    if (diff > maxv) diff = maxv;
    if (diff < -maxv) diff = -maxv;
    if (diff < 0) begin
      left = maxv + diff;
      right = maxv;
    end else begin
      left = maxv;
      right = maxv - diff;
    end
    // first matching end condition wins
    kind = plfd_pkg::END_CONTINUE;
    if (s.lvl_l < plfd_pkg::LOST_LEVEL && s.lvl_c < plfd_pkg::LOST_LEVEL &&
        s.lvl_r < plfd_pkg::LOST_LEVEL) begin
      kind = plfd_pkg::END_LOST;
    end else if (s.lvl_fl > plfd_pkg::SIDE_LEVEL || s.lvl_fr > plfd_pkg::SIDE_LEVEL) begin
      kind = plfd_pkg::END_BRANCH;
    end else if (cur_stop && s.lvl_fl > plfd_pkg::DARK_OUTER &&
                 s.lvl_l > plfd_pkg::DARK_INNER && s.lvl_c > plfd_pkg::DARK_INNER &&
                 s.lvl_r > plfd_pkg::DARK_INNER && s.lvl_fr > plfd_pkg::DARK_OUTER) begin
      kind = plfd_pkg::END_DARK;
    end
    if (cur_stop && kind != plfd_pkg::END_CONTINUE) begin
      left = 0;
      right = 0;
    end
    res.left_drive = left[plfd_pkg::SpeedW-1:0];
    res.right_drive = right[plfd_pkg::SpeedW-1:0];
    res.kind = kind;
    return res;
  endfunction

  function automatic plfd_pkg::sample_t mk(input int pos, input int fl, input int l,
                                           input int c, input int r, input int fr,
                                           input bit seg);
    plfd_pkg::sample_t s;
    s.pos = plfd_pkg::PosW'(pos);
    s.lvl_fl = plfd_pkg::LevelW'(fl);
    s.lvl_l = plfd_pkg::LevelW'(l);
    s.lvl_c = plfd_pkg::LevelW'(c);
    s.lvl_r = plfd_pkg::LevelW'(r);
    s.lvl_fr = plfd_pkg::LevelW'(fr);
    s.seg_start = seg;
    return s;
  endfunction

  // Pick a level one below, at or one above a sensor threshold
  function automatic logic [plfd_pkg::LevelW-1:0] near_threshold();
    int base;
    base = $urandom_range(0, 1) ? 100 : 200;
    return plfd_pkg::LevelW'(base + int'($urandom_range(0, 2)) - 1);
  endfunction

  // Mostly sensor patterns seen on a track, some fully random noise
  function automatic plfd_pkg::sample_t rand_sample();
    plfd_pkg::sample_t s;
    case ($urandom_range(0, 7))
      0: s.pos = plfd_pkg::PosW'($urandom_range(0, 4095));
      1: s.pos = plfd_pkg::PosW'($urandom_range(1900, 2100));
      default: s.pos = plfd_pkg::PosW'($urandom_range(0, 4000));
    endcase
    s.lvl_fl = plfd_pkg::LevelW'($urandom_range(0, 1023));
    s.lvl_l = plfd_pkg::LevelW'($urandom_range(0, 1023));
    s.lvl_c = plfd_pkg::LevelW'($urandom_range(0, 1023));
    s.lvl_r = plfd_pkg::LevelW'($urandom_range(0, 1023));
    s.lvl_fr = plfd_pkg::LevelW'($urandom_range(0, 1023));
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // following the line: dark middle, light outer sensors
        s.lvl_fl = plfd_pkg::LevelW'($urandom_range(0, 200));
        s.lvl_c = plfd_pkg::LevelW'($urandom_range(100, 1000));
        s.lvl_fr = plfd_pkg::LevelW'($urandom_range(0, 200));
      end
      3: begin
        s.lvl_l = plfd_pkg::LevelW'($urandom_range(0, 99));
        s.lvl_c = plfd_pkg::LevelW'($urandom_range(0, 99));
        s.lvl_r = plfd_pkg::LevelW'($urandom_range(0, 99));
      end
      4: begin
        if ($urandom_range(0, 1)) s.lvl_fl = plfd_pkg::LevelW'($urandom_range(201, 1023));
        else s.lvl_fr = plfd_pkg::LevelW'($urandom_range(201, 1023));
      end
      5, 6: begin
        s.lvl_fl = plfd_pkg::LevelW'($urandom_range(101, 200));
        s.lvl_l = plfd_pkg::LevelW'($urandom_range(201, 1023));
        s.lvl_c = plfd_pkg::LevelW'($urandom_range(201, 1023));
        s.lvl_r = plfd_pkg::LevelW'($urandom_range(201, 1023));
        s.lvl_fr = plfd_pkg::LevelW'($urandom_range(101, 200));
      end
      7: begin
        s.lvl_fl = near_threshold();
        s.lvl_l = near_threshold();
        s.lvl_c = near_threshold();
        s.lvl_r = near_threshold();
        s.lvl_fr = near_threshold();
      end
      default: ;
    endcase
    s.seg_start = ($urandom_range(0, 15) == 0);
    return s;
  endfunction

  // Offer one request after a random gap and record its expected drives on acceptance
  task automatic send_sample(input plfd_pkg::sample_t s);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, s.lvl_fr, s.lvl_r, s.lvl_c, s.lvl_l, s.lvl_fl, s.pos};
    in_tuser <= s.seg_start;
    do @(posedge clk); while (!in_tready);
    drive_q.push_back(predict_drive(s));
  endtask

  // Drop valid and wait until every expected result is out and the pipeline is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write all four registers back to back; only call while idle
  task automatic apply_config(input logic [plfd_pkg::SpeedW-1:0] speed,
                              input logic [plfd_pkg::GainW-1:0] gain,
                              input logic halve, input logic stop);
    cfg_we <= 1'b1;
    cfg_addr <= plfd_pkg::REG_MAX_SPEED;
    cfg_wdata <= speed;
    @(posedge clk);
    cfg_addr <= plfd_pkg::REG_DERIV_GAIN;
    cfg_wdata <= plfd_pkg::CfgDataW'(gain);
    @(posedge clk);
    cfg_addr <= plfd_pkg::REG_DERIV_HALVE;
    cfg_wdata <= plfd_pkg::CfgDataW'(halve);
    @(posedge clk);
    cfg_addr <= plfd_pkg::REG_FULL_STOP;
    cfg_wdata <= plfd_pkg::CfgDataW'(stop);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_speed = speed;
    cur_gain = gain;
    cur_halve = halve;
    cur_stop = stop;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_sample(rand_sample());
    settle();
  endtask

  // Register defaults: position extremes, truncation, end detection without full stop
  task automatic test_default_regs();
    send_sample(mk(2000, 0, 0, 500, 0, 0, 1'b0));
    send_sample(mk(4000, 0, 0, 500, 0, 0, 1'b0));
    send_sample(mk(0, 0, 0, 500, 0, 0, 1'b0));
    send_sample(mk(4095, 1023, 1023, 1023, 1023, 1023, 1'b0));
    send_sample(mk(4001, 0, 0, 500, 0, 0, 1'b0));
    send_sample(mk(1981, 0, 0, 500, 0, 0, 1'b0));
    send_sample(mk(2001, 0, 0, 500, 0, 0, 1'b0));
    // odd negative change: halving truncates toward zero
    send_sample(mk(2000, 0, 0, 500, 0, 0, 1'b0));
    send_sample(mk(2019, 500, 99, 99, 99, 500, 1'b0));
    send_sample(mk(2000, 0, 100, 99, 99, 0, 1'b0));
    send_sample(mk(2000, 201, 500, 500, 500, 0, 1'b0));
    // all dark is not reported while full stop is off
    send_sample(mk(2000, 200, 500, 500, 500, 200, 1'b0));
    send_sample(mk(2000, 0, 500, 500, 500, 201, 1'b0));
    send_sample(mk(3000, 0, 0, 500, 0, 0, 1'b1));
    send_sample(mk(0, 0, 0, 0, 0, 0, 1'b1));
    settle();
  endtask

  // Full stop: every end zeroes the drives, dark needs all levels past their bounds
  task automatic test_full_stop_ends();
    apply_config(plfd_pkg::MAX_SPEED_RST, plfd_pkg::DERIV_GAIN_RST,
                 plfd_pkg::DERIV_HALVE_RST, 1'b1);
    send_sample(mk(2500, 0, 0, 500, 0, 0, 1'b0));
    send_sample(mk(2500, 101, 201, 201, 201, 101, 1'b0));
    send_sample(mk(2500, 100, 201, 201, 201, 101, 1'b0));
    send_sample(mk(2500, 101, 200, 201, 201, 101, 1'b0));
    send_sample(mk(1500, 150, 1000, 1000, 1000, 150, 1'b0));
    send_sample(mk(1500, 0, 50, 20, 99, 0, 1'b0));
    send_sample(mk(1500, 0, 500, 500, 500, 300, 1'b0));
    send_sample(mk(1500, 1023, 1023, 1023, 1023, 1023, 1'b0));
    settle();
  endtask

  // Walk through register settings, the extremes among them
  task automatic test_register_sweep();
    apply_config(8'd0, 4'd0, 1'b0, 1'b0);
    run_random(55);
    apply_config(8'd255, 4'd15, 1'b0, 1'b0);
    run_random(55);
    // a stretch with no idling on either side
    gap_max = 0;
    stall_max = 0;
    apply_config(8'd255, 4'd15, 1'b1, 1'b1);
    run_random(55);
    gap_max = 6;
    stall_max = 6;
    apply_config(8'd1, 4'd8, 1'b0, 1'b1);
    run_random(55);
    apply_config(plfd_pkg::SpeedW'($urandom_range(0, 255)),
                 plfd_pkg::GainW'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    run_random(55);
  endtask

  // Hold off the result side so the pipeline fills and stalls its input
  task automatic test_backpressure();
    apply_config(8'd128, 4'd5, 1'b1, 1'b0);
    gap_max = 0;
    rx_hold_off = 60;
    repeat (40) send_sample(rand_sample());
    gap_max = 6;
    run_random(40);
  endtask

  // Build up the integral with a full-right run, then follow it with random positions
  task automatic test_integral_saturation();
    int k;
    gap_max = 0;
    stall_max = 0;
    apply_config(8'd255, 4'd0, 1'b0, 1'b0);
    send_sample(mk(4000, 0, 0, 800, 0, 0, 1'b1));
    for (k = 1; k < SatRunLen; k++) send_sample(mk(4000, 0, 0, 800, 0, 0, 1'b0));
    gap_max = 6;
    stall_max = 6;
    repeat (30) send_sample(mk($urandom_range(0, 4000), 0, 0, 800, 0, 0, 1'b0));
    settle();
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= plfd_pkg::REG_MAX_SPEED;
    cfg_wdata <= '0;
    cur_speed = plfd_pkg::MAX_SPEED_RST;
    cur_gain = plfd_pkg::DERIV_GAIN_RST;
    cur_halve = plfd_pkg::DERIV_HALVE_RST;
    cur_stop = plfd_pkg::FULL_STOP_RST;
    last_err = 0;
    err_acc = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_default_regs();
    test_full_stop_ends();
    test_register_sweep();
    test_backpressure();
    test_integral_saturation();
    if (failures == 0) begin
      $display("pid_line_follow_drive_core test passed");
    end else begin
      $display("pid_line_follow_drive_core test failed");
    end
    $finish;
  end

  // Accept results with random stalls and compare each with the oldest expectation
  initial begin : result_sink
    int               rx_wait;
    plfd_pkg::drive_t want;
    rx_wait = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (drive_q.size() == 0) begin
          $error("result with no request waiting: left %0d right %0d kind %0d",
                 out_tdata[7:0], out_tdata[15:8], out_tuser);
          failures++;
        end else begin
          want = drive_q.pop_front();
          if (out_tdata[7:0] !== want.left_drive) begin
            $error("left_drive mismatch: expected %0d, actual %0d",
                   want.left_drive, out_tdata[7:0]);
            failures++;
          end
          if (out_tdata[15:8] !== want.right_drive) begin
            $error("right_drive mismatch: expected %0d, actual %0d",
                   want.right_drive, out_tdata[15:8]);
            failures++;
          end
          if (out_tuser !== want.kind) begin
            $error("end_kind mismatch: expected %0d, actual %0d", want.kind, out_tuser);
            failures++;
          end
        end
        rx_wait = $urandom_range(0, stall_max);
      end
      if (rx_hold_off > 0) begin
        rx_hold_off--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // End the run when neither side has moved for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("pid_line_follow_drive_core test failed");
    $finish;
  end

endmodule

// File: filelist.f
design/plfd_pkg.sv
design/plfd_loop.sv
design/plfd_integ.sv
design/plfd_drive.sv
design/pid_line_follow_drive_core.sv
design/plfd_checker.sv
test/pid_line_follow_drive_core_tb.sv
